/* hw/rtl/sacf_pkg.sv */
// ----------------------------------------------------------------------------
// sacf_pkg
// Shared sizes, types and register codes of the set-associative cache model.
// ----------------------------------------------------------------------------
package sacf_pkg;

	localparam int MAX_SETS   = 64;
	localparam int MAX_WAYS   = 8;
	localparam int ADDR_WIDTH = 32;

	localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAYS_W = $clog2(MAX_WAYS + 1);

	// Fixed widths of the register and result fields.
	localparam int OFFSET_W   = 5;
	localparam int SETBITS_W  = 3;
	localparam int WAYSREG_W  = 4;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int SET_OUT_W  = 6;
	localparam int WAY_OUT_W  = 3;
	localparam int CNT_W      = 32;

	localparam logic [OFFSET_W-1:0]  OFFSET_RST  = OFFSET_W'(4);
	localparam logic [SETBITS_W-1:0] SETBITS_RST = SETBITS_W'(4);
	localparam logic [WAYSREG_W-1:0] WAYS_RST    = WAYSREG_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_BITS = 2'd0,
		CFG_SET_BITS    = 2'd1,
		CFG_WAYS        = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	// One memory row holds a whole set: per-way valid bits, tags and the
	// replacement pointer.
	typedef struct packed {
		logic [MAX_WAYS-1:0]                 valid;
		logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
		logic [WAY_W-1:0]                    ptr;
	} row_t;

	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] way;
		row_t             row;
	} lookup_t;

endpackage

/* hw/rtl/sacf_lookup.sv */
// ----------------------------------------------------------------------------
// sacf_lookup
// Tag compare over one set row and FIFO replacement of the row on a miss.
// ----------------------------------------------------------------------------
module sacf_lookup (
	input  sacf_pkg::row_t                      row,
	input  logic [sacf_pkg::ADDR_WIDTH-1:0]     block,
	input  logic [sacf_pkg::WAYS_W-1:0]         nways,
	output sacf_pkg::lookup_t                   lk
);
	import sacf_pkg::*;

	logic [MAX_WAYS-1:0] match;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    ptr;
	logic [WAYS_W-1:0]   ptr_inc;
	logic [WAY_W-1:0]    ptr_next;

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			match[w] = (WAYS_W'(w) < nways) && row.valid[w] && (row.tag[w] == block);
		end
		// Lowest matching way wins.
		hit_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
		end
	end

	always_comb begin
		// A pointer left over from a larger way count restarts at way 0.
		ptr = row.ptr;
		if (WAYS_W'(ptr) >= nways) begin
			ptr = '0;
		end
		ptr_inc  = WAYS_W'(ptr) + WAYS_W'(1);
		ptr_next = (ptr_inc == nways) ? '0 : ptr_inc[WAY_W-1:0];
	end

	always_comb begin
		lk.hit = |match;
		lk.row = row;
		if (lk.hit) begin
			lk.way = hit_way;
		end else begin
			lk.way              = ptr;
			lk.row.valid[ptr]   = 1'b1;
			lk.row.tag[ptr]     = block;
			lk.row.ptr          = ptr_next;
		end
	end

endmodule

/* hw/rtl/set_associative_cache_fifo.sv */
// ----------------------------------------------------------------------------
// set_associative_cache_fifo
// Tag-only set-associative cache with FIFO replacement and hit/miss counters.
// ----------------------------------------------------------------------------
// Each input transfer carries one byte address. The block address (address
// shifted right by offset_bits) picks a set with its low set_bits bits, and
// is compared against the valid tags of the first "ways" ways (1 to 8).
// A miss fills the way named by the set's FIFO pointer. Every access yields
// one result transfer with hit, set, way and the running hit and miss counts.
// An access reads the set's row from the tag memory into a register at
// the input transfer, then the lookup state compares and writes the row
// back. No address is taken during the lookup; the result sits in an
// output register, so the next address is taken while it waits, and the
// lookup only waits when a new result is ready and the old one is still
// stalled. Reset takes effect at once: a valid flag per set row marks rows
// never written, so no clearing pass runs. Configuration may only change
// while no access is in flight; nothing is flushed when it does.
// ----------------------------------------------------------------------------
module set_associative_cache_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sacf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sacf_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Address input channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [31:0]                      address,
	// Result channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             hit,
	output logic [sacf_pkg::SET_OUT_W-1:0]   set_index,
	output logic [sacf_pkg::WAY_OUT_W-1:0]   way_index,
	output logic [sacf_pkg::CNT_W-1:0]       hit_count,
	output logic [sacf_pkg::CNT_W-1:0]       miss_count
);
	import sacf_pkg::*;

	// Configuration registers.
	logic [OFFSET_W-1:0]  offset_q;
	logic [SETBITS_W-1:0] set_bits_q;
	logic [WAYSREG_W-1:0] ways_q;

	// Effective configuration, saturated to the storage that exists.
	logic [SETBITS_W-1:0] sb_eff;
	logic [WAYS_W-1:0]    nways;
	logic [SET_W:0]       one_sh;
	logic [SET_W:0]       mask_wide;
	logic [SET_W-1:0]     set_mask;

	logic [ADDR_WIDTH-1:0] block_c;
	logic [SET_W-1:0]      set_c;

	state_t state_q;
	state_t state_d;
	logic   accept;
	logic   done;
	logic   wr_en;

	// Tag memory: one row per set, plus a flag per row that says it was written.
	row_t               tag_mem [MAX_SETS];
	logic [MAX_SETS-1:0] row_vld_q;

	row_t                  rd_row_s1;
	logic                  rowv_s1;
	logic [ADDR_WIDTH-1:0] block_s1;
	logic [SET_W-1:0]      set_s1;
	row_t                  row_eff;
	lookup_t               lk;

	logic                  out_valid_q;
	logic                  hit_q;
	logic [SET_W-1:0]      set_q;
	logic [WAY_W-1:0]      way_q;
	logic [CNT_W-1:0]      hit_cnt_q;
	logic [CNT_W-1:0]      miss_cnt_q;

	// The configuration port takes every write; the user must write only while idle, the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= OFFSET_RST;
			set_bits_q <= SETBITS_RST;
			ways_q     <= WAYS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_OFFSET_BITS: offset_q   <= cfg_data[OFFSET_W-1:0];
				CFG_SET_BITS:    set_bits_q <= cfg_data[SETBITS_W-1:0];
				CFG_WAYS:        ways_q     <= cfg_data[WAYSREG_W-1:0];
				default: begin
					// Writes to unknown indexes are dropped.
				end
			endcase
		end
	end

	always_comb begin
		sb_eff = (32'(set_bits_q) > 32'(SET_W)) ? SETBITS_W'(SET_W) : set_bits_q;
		if (ways_q == '0) begin
			nways = WAYS_W'(1);
		end else if (32'(ways_q) > 32'(MAX_WAYS)) begin
			nways = WAYS_W'(MAX_WAYS);
		end else begin
			nways = WAYS_W'(ways_q);
		end
	end

	assign one_sh    = (SET_W + 1)'(1) << sb_eff;
	assign mask_wide = one_sh - (SET_W + 1)'(1);
	assign set_mask  = mask_wide[SET_W-1:0];

	// Set selection straight from the incoming address, for the row read.
	assign block_c = address[ADDR_WIDTH-1:0] >> offset_q;
	assign set_c   = block_c[SET_W-1:0] & set_mask;

	// Sequencer: idle takes an address, lookup finishes once the output
	// register is free (or being emptied in the same cycle).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		done     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (!out_valid_q || !out_stall) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && !in_stall;
	// Hits leave the row unchanged, so only a miss writes it back. The row
	// is read again only at the next input transfer, after this write, so
	// two accesses to one set never overlap.
	assign wr_en  = done && !lk.hit;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_row_s1 <= tag_mem[set_c];
		end
		if (wr_en) begin
			tag_mem[set_s1] <= lk.row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[set_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rowv_s1  <= row_vld_q[set_c];
			block_s1 <= block_c;
			set_s1   <= set_c;
		end
	end

	// A row that was never written reads as empty with its pointer at way 0.
	always_comb begin
		row_eff = rd_row_s1;
		if (!rowv_s1) begin
			row_eff.valid = '0;
			row_eff.ptr   = '0;
		end
	end

	sacf_lookup u_lookup (
		.row   (row_eff),
		.block (block_s1),
		.nways (nways),
		.lk    (lk)
	);

	// Result register. The counters change only when a result is loaded, so
	// they double as the count fields of the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
		end else begin
			if (done) begin
				out_valid_q <= 1'b1;
				if (lk.hit) begin
					hit_cnt_q <= hit_cnt_q + CNT_W'(1);
				end else begin
					miss_cnt_q <= miss_cnt_q + CNT_W'(1);
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			hit_q <= lk.hit;
			set_q <= set_s1;
			way_q <= lk.way;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign set_index  = SET_OUT_W'(set_q);
	assign way_index  = WAY_OUT_W'(way_q);
	assign hit_count  = hit_cnt_q;
	assign miss_count = miss_cnt_q;

endmodule

/* hw/rtl/sacf_checker.sv */
// ----------------------------------------------------------------------------
// sacf_checker
// Port-level checks of the cache model, bound to the top level.
// ----------------------------------------------------------------------------
module sacf_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             hit,
	input  logic [sacf_pkg::SET_OUT_W-1:0]   set_index,
	input  logic [sacf_pkg::WAY_OUT_W-1:0]   way_index,
	input  logic [sacf_pkg::CNT_W-1:0]       hit_count,
	input  logic [sacf_pkg::CNT_W-1:0]       miss_count
);
	import sacf_pkg::*;

	logic             out_xfer;
	logic [CNT_W-1:0] last_hit_q;
	logic [CNT_W-1:0] last_miss_q;

	assign out_xfer = out_valid && !out_stall;

	// Counts seen in the last result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_hit_q  <= '0;
			last_miss_q <= '0;
		end else if (out_xfer) begin
			last_hit_q  <= hit_count;
			last_miss_q <= miss_count;
		end
	end

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(set_index)
			&& $stable(way_index) && $stable(hit_count) && $stable(miss_count))
		else $error("stalled result changed");

	// An accepted access occupies the block: the input stalls during its lookup.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("address taken during lookup");

	// Each hit result advances the hit count by one and leaves misses alone.
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && hit |-> (hit_count == last_hit_q + CNT_W'(1))
			&& (miss_count == last_miss_q))
		else $error("hit count out of step");

	// Each miss result advances the miss count by one and leaves hits alone.
	a_miss_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !hit |-> (miss_count == last_miss_q + CNT_W'(1))
			&& (hit_count == last_hit_q))
		else $error("miss count out of step");

endmodule

bind set_associative_cache_fifo sacf_checker u_sacf_checker (.*);

/* sim/set_associative_cache_fifo_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_associative_cache_fifo_test
// Self-checking testbench for the tag-only FIFO-replacement cache model.
// ----------------------------------------------------------------------------
// A behavioral copy of the cache (valid bits, tags, FIFO pointers and the two
// running counters) predicts every lookup as its address transfer is taken.
// Each result transfer is then compared field by field with the oldest
// prediction. A short directed sequence covers the edge cases, and several
// configuration phases follow, each one driven with random addresses that
// mostly revisit a small pool of hot lines. Random stalls on the result
// channel run throughout; random address gaps run outside gap-free runs.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic                           hit;
	logic [sacf_pkg::SET_OUT_W-1:0] set_index;
	logic [sacf_pkg::WAY_OUT_W-1:0] way_index;
	logic [sacf_pkg::CNT_W-1:0]     hit_count;
	logic [sacf_pkg::CNT_W-1:0]     miss_count;
} lookup_result_t;

class cache_scoreboard;
	bit                         line_valid [sacf_pkg::MAX_SETS * sacf_pkg::MAX_WAYS];
	logic [31:0]                line_tag [sacf_pkg::MAX_SETS * sacf_pkg::MAX_WAYS];
	int unsigned                fifo_ptr [sacf_pkg::MAX_SETS];
	logic [31:0]                hits;
	logic [31:0]                misses;
	logic [4:0]                 offset_bits;
	logic [2:0]                 set_bits;
	logic [3:0]                 ways;
	lookup_result_t             pending_lookups [$];
	int                         errors;

	function new();
		for (int i = 0; i < sacf_pkg::MAX_SETS * sacf_pkg::MAX_WAYS; i++) begin
			line_valid[i] = 1'b0;
			line_tag[i] = '0;
		end
		for (int s = 0; s < sacf_pkg::MAX_SETS; s++)
			fifo_ptr[s] = 0;
		hits = '0;
		misses = '0;
		offset_bits = sacf_pkg::OFFSET_RST;
		set_bits = sacf_pkg::SETBITS_RST;
		ways = sacf_pkg::WAYS_RST;
		errors = 0;
	endfunction

	function void write_register(logic [sacf_pkg::CFG_IDX_W-1:0] idx,
			logic [sacf_pkg::CFG_DATA_W-1:0] data);
		case (idx)
		sacf_pkg::CFG_OFFSET_BITS: begin
			offset_bits = data[4:0];
		end
		sacf_pkg::CFG_SET_BITS: begin
			set_bits = data[2:0];
		end
		sacf_pkg::CFG_WAYS: begin
			ways = data[3:0];
		end
		default: begin
			// Writes to unmapped indexes leave the cache configuration alone.
		end
		endcase
	endfunction

	// Looks up one address, updates the cache copy and queues the result.
	function void note_access(logic [31:0] addr);
		logic [31:0]    blk;
		int unsigned    used_set_bits;
		int unsigned    nways;
		int unsigned    set;
		int unsigned    base;
		int unsigned    way;
		int unsigned    ptr;
		bit             found;
		lookup_result_t r;
		blk = addr >> offset_bits;
		// MAX_SETS is a power of two, so SET_W is the largest usable set_bits.
		used_set_bits = (set_bits > sacf_pkg::SET_W) ? sacf_pkg::SET_W : set_bits;
		if (ways == 0)
			nways = 1;
		else if (ways > sacf_pkg::MAX_WAYS)
			nways = sacf_pkg::MAX_WAYS;
		else
			nways = ways;
		set = blk & ((32'd1 << used_set_bits) - 32'd1);
		base = set * sacf_pkg::MAX_WAYS;
		found = 1'b0;
		way = 0;
		for (int w = 0; w < nways; w++) begin
			if (!found && line_valid[base + w] && line_tag[base + w] == blk) begin
				found = 1'b1;
				way = w;
			end
		end
		if (found) begin
			hits = hits + 32'd1;
		end else begin
			// A pointer left over from a larger way count restarts at way 0.
			ptr = fifo_ptr[set];
			if (ptr >= nways)
				ptr = 0;
			way = ptr;
			line_valid[base + way] = 1'b1;
			line_tag[base + way] = blk;
			fifo_ptr[set] = (ptr + 1) % nways;
			misses = misses + 32'd1;
		end
		r.hit = found;
		r.set_index = sacf_pkg::SET_OUT_W'(set);
		r.way_index = sacf_pkg::WAY_OUT_W'(way);
		r.hit_count = hits;
		r.miss_count = misses;
		pending_lookups.push_back(r);
	endfunction

	function void flag(string msg);
		errors++;
		$display("%s", msg);
	endfunction

	function void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got)
			flag($sformatf("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got));
	endfunction

	function void check_result(lookup_result_t got);
		lookup_result_t want;
		if (pending_lookups.size() == 0) begin
			flag($sformatf("%0t: result transfer with no lookup outstanding", $time));
			return;
		end
		want = pending_lookups.pop_front();
		compare_field("hit", 32'(want.hit), 32'(got.hit));
		compare_field("set_index", 32'(want.set_index), 32'(got.set_index));
		compare_field("way_index", 32'(want.way_index), 32'(got.way_index));
		compare_field("hit_count", want.hit_count, got.hit_count);
		compare_field("miss_count", want.miss_count, got.miss_count);
	endfunction
endclass

module set_associative_cache_fifo_test;
	import sacf_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 7;
	// Settle time after the last result, to cover the result register.
	localparam int SETTLE_CYCLES = 4;
	// The long result hold-off used to fill the block and stall its input.
	localparam int LONG_HOLD_CYCLES = 80;
	// No correct run goes this long without a single transfer: the longest
	// quiet stretch is the long hold-off plus a stall burst and a sender gap.
	localparam int IDLE_LIMIT = 1000;
	localparam int PHASE_COUNT = 8;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int POOL_SIZE = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [31:0]           address;
	logic                  out_valid;
	logic                  out_stall;
	logic                  hit;
	logic [SET_OUT_W-1:0]  set_index;
	logic [WAY_OUT_W-1:0]  way_index;
	logic [CNT_W-1:0]      hit_count;
	logic [CNT_W-1:0]      miss_count;

	cache_scoreboard lookups = new();

	// Requests from the stimulus to the result-side stall process.
	bit          hold_results_req = 1'b0;
	// While set, the address sender offers back to back with no gaps.
	bit          sender_steady = 1'b0;
	// Offset currently programmed, used to pick bytes within a hot line.
	int unsigned cur_offset = OFFSET_RST;
	logic [31:0] hot_blocks [POOL_SIZE];
	int unsigned quiet_cycles = 0;

	// Configurations of the random phases: offset_bits, set_bits, ways as
	// written. Some values exercise saturation: set_bits 7 and ways 15 clamp
	// to the maximum, 30 masks to set_bits 6, and 16 masks to ways 0, which
	// behaves as one way. Phase 6 lowers the way count of phase 5 so that
	// many sets are left with pointers beyond the new way count.
	int unsigned phase_cfg [PHASE_COUNT][3] = '{
		'{2, 3, 2},
		'{0, 0, 1},
		'{31, 7, 15},
		'{6, 6, 8},
		'{3, 30, 16},
		'{4, 2, 8},
		'{4, 2, 3},
		'{1, 5, 5}
	};

	set_associative_cache_fifo u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.address    (address),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.set_index  (set_index),
		.way_index  (way_index),
		.hit_count  (hit_count),
		.miss_count (miss_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Result checking. Outputs are sampled at the edge before the block's
	// own updates land, so a transfer is seen exactly as it was accepted.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			lookups.check_result('{hit, set_index, way_index, hit_count, miss_count});
	end

	// Watchdog: any transfer on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result-side stall pattern. Most stretches are short, some are long, and
	// some are long runs with no stall at all. On request it holds off for a
	// long stretch, counted here, so that the block backs up into its input.
	initial begin : result_backpressure
		int unsigned r;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_results_req) begin
				hold_results_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (r < 55) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else if (r < 62) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(30, 80)) @(posedge clk);
			end else if (r < 92) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	// Gap after an address transfer: mostly none, often short, and now and
	// then a long pause.
	function automatic int unsigned pick_input_gap();
		int unsigned r;
		if (sender_steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offers one address and holds it until the block takes it. With no gap
	// drawn, in_valid stays high for the next call.
	task automatic send_access(input logic [31:0] addr);
		int unsigned gap;
		in_valid <= 1'b1;
		address <= addr;
		do @(posedge clk); while (in_stall);
		lookups.note_access(addr);
		gap = pick_input_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Writes one register. cfg_valid stays high so that writes can follow
	// back to back; the caller lowers it after the last one.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		lookups.write_register(idx, data);
		if (idx == CFG_OFFSET_BITS)
			cur_offset = data;
	endtask

	// Stops offering addresses and waits until every lookup has come back,
	// then lets the block settle so that it is idle for a register write.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (lookups.pending_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reconfigure(input int unsigned offs, input int unsigned sets,
			input int unsigned nways);
		drain_results();
		write_register(CFG_OFFSET_BITS, CFG_DATA_W'(offs));
		write_register(CFG_SET_BITS, CFG_DATA_W'(sets));
		write_register(CFG_WAYS, CFG_DATA_W'(nways));
		cfg_valid <= 1'b0;
	endtask

	// Random address: a quarter are fully random, the rest pick a byte within
	// one of the hot lines so that hits, conflicts and evictions are common.
	// A hot line is replaced now and then to keep fresh misses coming.
	function automatic logic [31:0] random_address();
		int unsigned r;
		logic [31:0] line_mask;
		logic [31:0] a;
		r = $urandom_range(0, 99);
		if (r < 5)
			hot_blocks[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
		if (r < 25)
			return $urandom;
		a = hot_blocks[$urandom_range(0, POOL_SIZE - 1)];
		line_mask = (32'd1 << cur_offset) - 32'd1;
		return (a & ~line_mask) | ($urandom & line_mask);
	endfunction

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_OFFSET_BITS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		address <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: 16-byte lines, 16 sets, 4 ways. The first
		// accesses hit opposite address extremes, then the same line again
		// through another byte of it.
		sender_steady = 1'b1;
		send_access(32'h0000_0000);
		send_access(32'hFFFF_FFFF);
		send_access(32'h0000_000F);
		// Fill set 0 and wrap its FIFO pointer: the fifth line evicts way 0,
		// so the first line misses again and lands in way 1.
		send_access(32'h0000_0100);
		send_access(32'h0000_0200);
		send_access(32'h0000_0300);
		send_access(32'h0000_0400);
		send_access(32'h0000_0000);
		send_access(32'hFFFF_FFF0);
		send_access(32'h0000_0400);

		// Raise the way count with lines kept in place, and push the pointer
		// of set 0 out to way 5.
		drain_results();
		write_register(CFG_WAYS, CFG_DATA_W'(8));
		cfg_valid <= 1'b0;
		send_access(32'h0000_0500);
		send_access(32'h0000_0600);
		send_access(32'h0000_0700);

		// Lower the way count below that pointer: the next miss in set 0
		// restarts at way 0, and the line in way 4 is no longer searched.
		drain_results();
		write_register(CFG_WAYS, CFG_DATA_W'(2));
		cfg_valid <= 1'b0;
		send_access(32'h0000_0800);
		send_access(32'h0000_0700);

		// A write to the unmapped index must change nothing, then the
		// largest offset with set and way counts above their maximum.
		drain_results();
		write_register(CFG_UNMAPPED, CFG_DATA_W'(5'h1F));
		write_register(CFG_OFFSET_BITS, CFG_DATA_W'(31));
		write_register(CFG_SET_BITS, CFG_DATA_W'(7));
		write_register(CFG_WAYS, CFG_DATA_W'(15));
		cfg_valid <= 1'b0;
		send_access(32'h8000_0000);
		send_access(32'h7FFF_FFFF);
		send_access(32'hFFFF_FFFF);
		send_access(32'h0000_0000);

		// Byte-sized lines, a single set and a way count of zero, which
		// behaves as one way: each new line evicts the previous one.
		reconfigure(0, 0, 0);
		send_access(32'h1234_5678);
		send_access(32'h1234_5678);
		send_access(32'hEDCB_A987);
		send_access(32'h1234_5678);
		sender_steady = 1'b0;

		// Random phases, with a random configuration at the end.
		for (int p = 0; p <= PHASE_COUNT; p++) begin
			if (p < PHASE_COUNT)
				reconfigure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
			else
				reconfigure($urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 31));
			for (int h = 0; h < POOL_SIZE; h++)
				hot_blocks[h] = $urandom;
			// In phase 3 the result side holds off for a long stretch while
			// addresses keep coming back to back, so the block fills up and
			// stalls its input. Phase 5 opens with a gap-free run as well.
			if (p == 3)
				hold_results_req = 1'b1;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				sender_steady = (p == 3 && i < 30) || (p == 5 && i < 40);
				send_access(random_address());
			end
			sender_steady = 1'b0;
		end

		drain_results();
		if (lookups.errors == 0 && lookups.pending_lookups.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/sacf_pkg.sv
hw/rtl/sacf_lookup.sv
hw/rtl/set_associative_cache_fifo.sv
hw/rtl/sacf_checker.sv
sim/set_associative_cache_fifo_test.sv
